// ----- sv/gcol_pkg.sv -----
// ----------------------------------------------------------------------------
// gcol_pkg
// Shared types for the grid cell object list table: request kinds, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gcol_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_FIND    = 2'd1,
        KIND_DEL_POS = 2'd2,
        KIND_DEL_HDL = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WAIT,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } t_state;

    localparam int unsigned LIMIT_W = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic base_ld;
        logic n_ld;
        logic idx_clr;
        logic idx_ld_pos;
        logic idx_inc;
        logic rd_next;
        logic ins_wr;
        logic hit;
        logic succ_set;
        logic shift_wr;
        logic dec_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic  clear_done;
        logic  oog;
        t_kind kind;
        logic  ins_ok;
        logic  pos_ok;
        logic  scan_end;
        logic  shift_end;
        logic  match;
    } t_dp_sts;

endpackage

// ----- sv/grid_cell_object_list_table.sv -----
// ----------------------------------------------------------------------------
// grid_cell_object_list_table
// Grid of cells, each holding an ordered list of object handles, with insert,
// find, delete at position and delete by handle requests.
//
// channel   direction  handshake              payload
// request   in         start, busy            i_kind, i_cell_x, i_cell_y,
//                                             i_handle, i_slot_index
// result    out        o_valid (one cycle)    o_success, o_found,
//                                             o_found_slot, o_cell_count
// limit     in         i_cfg_we               i_cfg_wdata
//
// slots are read one at a time from the single read port of the slot
// memory, each read result being registered before it is used.
// after reset busy stays high while the cell counts are cleared, one
// cell per cycle.
// the result strobe cannot be held off; the next request is taken the
// cycle after o_valid.
// ----------------------------------------------------------------------------
module grid_cell_object_list_table
    import gcol_pkg::*;
#(
    parameter int unsigned GRID_X   = 64,
    parameter int unsigned GRID_Y   = 64,
    parameter int unsigned CELL_CAP = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_cell_x,
    input  logic [5:0]  i_cell_y,
    input  logic [15:0] i_handle,
    input  logic [3:0]  i_slot_index,
    output logic        o_valid,
    output logic        o_success,
    output logic        o_found,
    output logic [3:0]  o_found_slot,
    output logic [4:0]  o_cell_count,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    gcol_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    gcol_dp #(
        .GRID_X   (GRID_X),
        .GRID_Y   (GRID_Y),
        .CELL_CAP (CELL_CAP)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_kind       (i_kind),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_handle     (i_handle),
        .i_slot_index (i_slot_index),
        .o_success    (o_success),
        .o_found      (o_found),
        .o_found_slot (o_found_slot),
        .o_cell_count (o_cell_count)
    );

endmodule

// ----- sv/gcol_ram.sv -----
// ----------------------------------------------------------------------------
// gcol_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gcol_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/gcol_ctrl.sv -----
// ----------------------------------------------------------------------------
// gcol_ctrl
// Request sequencer: count clearing after reset, count fetch, slot scan and
// slot shift down, result strobe.
// ----------------------------------------------------------------------------
module gcol_ctrl
    import gcol_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy,
    output logic    o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_CNT_RD;
            end
            ST_CNT_RD: begin
                n_state = i_sts.oog ? ST_RESP : ST_CNT_WAIT;
            end
            ST_CNT_WAIT: n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                unique case (i_sts.kind)
                    KIND_INSERT:  n_state = ST_RESP;
                    KIND_FIND:    n_state = ST_SCAN_RD;
                    KIND_DEL_HDL: n_state = ST_SCAN_RD;
                    KIND_DEL_POS: n_state = i_sts.pos_ok ? ST_SHIFT_RD : ST_RESP;
                    default:      n_state = ST_RESP;
                endcase
            end
            ST_SCAN_RD: begin
                n_state = i_sts.scan_end ? ST_RESP : ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (!i_sts.match) begin
                    n_state = ST_SCAN_RD;
                end else if (i_sts.kind == KIND_FIND) begin
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                n_state = i_sts.shift_end ? ST_RESP : ST_SHIFT_WR;
            end
            ST_SHIFT_WR: n_state = ST_SHIFT_RD;
            ST_RESP:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            ST_CNT_RD:   o_cmd.base_ld = 1'b1;
            ST_CNT_WAIT: begin
                o_cmd.n_ld    = 1'b1;
                o_cmd.idx_clr = 1'b1;
            end
            ST_DISPATCH: begin
                if (i_sts.kind == KIND_INSERT) begin
                    o_cmd.ins_wr = i_sts.ins_ok;
                end
                if (i_sts.kind == KIND_DEL_POS && i_sts.pos_ok) begin
                    o_cmd.idx_ld_pos = 1'b1;
                    o_cmd.succ_set   = 1'b1;
                end
            end
            ST_SCAN_RD: ;
            ST_SCAN_CMP: begin
                o_cmd.hit     = i_sts.match;
                o_cmd.idx_inc = !i_sts.match;
            end
            ST_SHIFT_RD: begin
                o_cmd.rd_next = 1'b1;
                o_cmd.dec_wr  = i_sts.shift_end;
            end
            ST_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
            end
            ST_RESP: o_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ----- sv/gcol_dp.sv -----
// ----------------------------------------------------------------------------
// gcol_dp
// Datapath: request registers, cell count and slot memories, scan index,
// compare and result registers, limit register.
// ----------------------------------------------------------------------------
module gcol_dp
    import gcol_pkg::*;
#(
    parameter int unsigned GRID_X   = 64,
    parameter int unsigned GRID_Y   = 64,
    parameter int unsigned CELL_CAP = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic [1:0]         i_kind,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic [15:0]        i_handle,
    input  logic [3:0]         i_slot_index,
    output logic               o_success,
    output logic               o_found,
    output logic [3:0]         o_found_slot,
    output logic [4:0]         o_cell_count
);

    localparam int unsigned NCELLS     = GRID_X * GRID_Y;
    localparam int unsigned CELL_W     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int unsigned SLOT_DEPTH = NCELLS * CELL_CAP;
    localparam int unsigned SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int unsigned CNT_W      = $clog2(CELL_CAP + 1);

    logic [LIMIT_W-1:0] r_limit;
    logic [CELL_W-1:0]  r_clr;
    t_kind              r_kind;
    logic [15:0]        r_handle;
    logic [3:0]         r_pos;
    logic [CELL_W-1:0]  r_cell;
    logic               r_oog;
    logic [SLOT_AW-1:0] r_base;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_idx;
    logic               r_success;
    logic               r_found;
    logic [3:0]         r_slot;

    logic [CELL_W-1:0]  n_cell;
    logic               cnt_we;
    logic [CELL_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [CNT_W-1:0]   cnt_rdata;
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [15:0]        slot_wdata;
    logic [SLOT_AW-1:0] slot_raddr;
    logic [15:0]        slot_rdata;

    assign n_cell = CELL_W'(i_cell_x) * CELL_W'(GRID_Y) + CELL_W'(i_cell_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_clr   <= '0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (i_cmd.clr_step) r_clr <= r_clr + CELL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= t_kind'(i_kind);
            r_handle  <= i_handle;
            r_pos     <= i_slot_index;
            r_cell    <= n_cell;
            r_oog     <= (int'(i_cell_x) >= GRID_X) || (int'(i_cell_y) >= GRID_Y);
            r_n       <= '0;
            r_success <= 1'b0;
            r_found   <= 1'b0;
            r_slot    <= '0;
        end
        if (i_cmd.base_ld) r_base <= SLOT_AW'(r_cell) * SLOT_AW'(CELL_CAP);
        if (i_cmd.n_ld) r_n <= cnt_rdata;
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_ld_pos) begin
            r_idx <= CNT_W'(r_pos);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.ins_wr) begin
            r_n       <= r_n + CNT_W'(1);
            r_success <= 1'b1;
        end
        if (i_cmd.dec_wr) r_n <= r_n - CNT_W'(1);
        if (i_cmd.succ_set) r_success <= 1'b1;
        if (i_cmd.hit) begin
            r_success <= 1'b1;
            r_found   <= 1'b1;
            r_slot    <= 4'(r_idx);
        end
    end

    // count memory
    assign cnt_we    = i_cmd.clr_step | i_cmd.ins_wr | i_cmd.dec_wr;
    assign cnt_waddr = i_cmd.clr_step ? r_clr : r_cell;

    always_comb begin
        priority if (i_cmd.clr_step) begin
            cnt_wdata = '0;
        end else if (i_cmd.ins_wr) begin
            cnt_wdata = r_n + CNT_W'(1);
        end else begin
            cnt_wdata = r_n - CNT_W'(1);
        end
    end

    gcol_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NCELLS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_cell),
        .o_rdata (cnt_rdata)
    );

    // slot memory
    assign slot_we    = i_cmd.ins_wr | i_cmd.shift_wr;
    assign slot_waddr = r_base + (i_cmd.ins_wr ? SLOT_AW'(r_n) : SLOT_AW'(r_idx));
    assign slot_wdata = i_cmd.ins_wr ? r_handle : slot_rdata;
    assign slot_raddr = r_base + SLOT_AW'(r_idx) + SLOT_AW'(i_cmd.rd_next);

    gcol_ram #(
        .WIDTH (16),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // status
    assign o_sts.clear_done = (r_clr == CELL_W'(NCELLS - 1));
    assign o_sts.oog        = r_oog;
    assign o_sts.kind       = r_kind;
    assign o_sts.ins_ok     = (int'(r_n) < int'(r_limit)) && (int'(r_n) < CELL_CAP);
    assign o_sts.pos_ok     = int'(r_pos) < int'(r_n);
    assign o_sts.scan_end   = (int'(r_idx) >= int'(r_n)) || (int'(r_idx) >= CELL_CAP);
    assign o_sts.shift_end  = (int'(r_idx) + 1 >= int'(r_n)) || (int'(r_idx) + 1 >= CELL_CAP);
    assign o_sts.match      = (slot_rdata == r_handle);

    assign o_success    = r_success;
    assign o_found      = r_found;
    assign o_found_slot = r_slot;
    assign o_cell_count = 5'(r_n);

endmodule

// ----- sv/gcol_checker.sv -----
// ----------------------------------------------------------------------------
// gcol_checker
// Port level checks of the request and result sequencing, bound to the top.
// ----------------------------------------------------------------------------
module gcol_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_success,
    input logic        o_found,
    input logic [3:0]  o_found_slot
);

    // counts are cleared after reset before any item is taken
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted item did not raise busy");

    a_valid_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy ##1 (!o_valid && !busy))
        else $error("result strobe not a single cycle at the end of an item");

    a_found_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_success)
        else $error("found without success");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_found_slot == 4'd0)
        else $error("slot set without a match");

endmodule

bind grid_cell_object_list_table gcol_checker u_gcol_checker (.*);

// ----- verif/grid_cell_object_list_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_object_list_table_checker
// Watches the request, result and limit ports of the grid cell table, keeps
// its own copy of every cell list and the cell limit, predicts the result of
// each accepted request and compares results field by field, in order.
// ----------------------------------------------------------------------------
module grid_cell_object_list_table_checker
    import gcol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_cell_x,
    input  logic [5:0]  i_cell_y,
    input  logic [15:0] i_handle,
    input  logic [3:0]  i_slot_index,
    input  logic        i_valid,
    input  logic        i_success,
    input  logic        i_found,
    input  logic [3:0]  i_found_slot,
    input  logic [4:0]  i_cell_count,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_checked
);

    localparam int CELL_CAP = 16;

    typedef struct {
        int          seq;
        t_kind       kind;
        logic [5:0]  x;
        logic [5:0]  y;
        logic        success;
        logic        found;
        logic [3:0]  found_slot;
        logic [4:0]  cell_count;
    } t_outcome;

    logic [4:0]  occupancy    [4096];
    logic [15:0] handle_store [65536];
    logic [4:0]  limit_now;
    t_outcome    awaited_outcomes [$];
    int          request_seq;
    int          mismatches;
    int          checked;

    initial begin
        request_seq   = 0;
        mismatches    = 0;
        checked       = 0;
        o_mismatches  = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 200) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want, input t_outcome w);
        if (got !== want) begin
            report_mismatch($sformatf("item %0d (%s at cell %0d,%0d): %s got %0h expected %0h",
                                      w.seq, w.kind.name(), w.x, w.y, name, got, want));
        end
    endtask

    function automatic void remove_slot(input logic [11:0] cell_id, input logic [3:0] pos);
        logic [4:0] n;
        int         i;
        int         j;
        n = occupancy[cell_id];
        for (i = int'(pos); i + 1 < int'(n); i++) begin
            j = i + 1;
            handle_store[{cell_id, i[3:0]}] = handle_store[{cell_id, j[3:0]}];
        end
        occupancy[cell_id] = n - 5'd1;
    endfunction

    function automatic t_outcome predict_request(input t_kind k, input logic [5:0] x,
                                                 input logic [5:0] y, input logic [15:0] h,
                                                 input logic [3:0] pos);
        t_outcome   r;
        logic [11:0] cell_id;
        logic [4:0]  n;
        int          hit;
        int          i;
        cell_id      = {x, y};
        n            = occupancy[cell_id];
        hit          = -1;
        r.seq        = request_seq;
        r.kind       = k;
        r.x          = x;
        r.y          = y;
        r.success    = 1'b0;
        r.found      = 1'b0;
        r.found_slot = '0;
        for (i = 0; i < int'(n) && i < CELL_CAP; i++) begin
            if (hit < 0 && handle_store[{cell_id, i[3:0]}] == h) begin
                hit = i;
            end
        end
        case (k)
            KIND_INSERT: begin
                if (n < limit_now && int'(n) < CELL_CAP) begin
                    handle_store[{cell_id, n[3:0]}] = h;
                    occupancy[cell_id] = n + 5'd1;
                    r.success = 1'b1;
                end
            end
            KIND_FIND: begin
                if (hit >= 0) begin
                    r.success    = 1'b1;
                    r.found      = 1'b1;
                    r.found_slot = hit[3:0];
                end
            end
            KIND_DEL_POS: begin
                if ({1'b0, pos} < n) begin
                    remove_slot(cell_id, pos);
                    r.success = 1'b1;
                end
            end
            default: begin
                if (hit >= 0) begin
                    r.found      = 1'b1;
                    r.found_slot = hit[3:0];
                    remove_slot(cell_id, hit[3:0]);
                    r.success    = 1'b1;
                end
            end
        endcase
        r.cell_count = occupancy[cell_id];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome fresh;
        if (!i_rst_n) begin
            foreach (occupancy[c]) occupancy[c] = '0;
            limit_now = LIMIT_RESET;
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                limit_now = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                fresh = predict_request(t_kind'(i_kind), i_cell_x, i_cell_y,
                                        i_handle, i_slot_index);
                awaited_outcomes.insert(awaited_outcomes.size(), fresh);
                request_seq++;
            end
            if (i_valid) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("success", 16'(i_success), 16'(want.success), want);
                    compare_field("found", 16'(i_found), 16'(want.found), want);
                    compare_field("found_slot", 16'(i_found_slot), 16'(want.found_slot), want);
                    compare_field("cell_count", 16'(i_cell_count), 16'(want.cell_count), want);
                    checked++;
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= awaited_outcomes.size();
        o_checked     <= checked;
    end

endmodule

// ----- verif/grid_cell_object_list_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_cell_object_list_table_tb
// Drives the grid cell table with directed list operations and then with
// bursts of random requests aimed at a few busy cells per phase, across a
// range of cell limits; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module grid_cell_object_list_table_tb;
    import gcol_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASE_ITEMS = 238;
    localparam int NUM_HOT     = 6;
    localparam int POOL_SIZE   = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = '0;
    logic [5:0]  cell_x = '0;
    logic [5:0]  cell_y = '0;
    logic [15:0] handle = '0;
    logic [3:0]  slot_index = '0;
    logic        valid;
    logic        success;
    logic        found;
    logic [3:0]  found_slot;
    logic [4:0]  cell_count;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int checked;
    int cycles = 0;
    int burst_left = 0;
    int sent_by_kind [4] = '{0, 0, 0, 0};
    int limit_writes = 0;

    always #5 clk = ~clk;

    grid_cell_object_list_table u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (kind),
        .i_cell_x     (cell_x),
        .i_cell_y     (cell_y),
        .i_handle     (handle),
        .i_slot_index (slot_index),
        .o_valid      (valid),
        .o_success    (success),
        .o_found      (found),
        .o_found_slot (found_slot),
        .o_cell_count (cell_count),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata)
    );

    grid_cell_object_list_table_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (kind),
        .i_cell_x      (cell_x),
        .i_cell_y      (cell_y),
        .i_handle      (handle),
        .i_slot_index  (slot_index),
        .i_valid       (valid),
        .i_success     (success),
        .i_found       (found),
        .i_found_slot  (found_slot),
        .i_cell_count  (cell_count),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // busy is sampled mid-cycle so the accepting edge is known exactly
    task automatic send_request(input t_kind k, input logic [5:0] x, input logic [5:0] y,
                                input logic [15:0] h, input logic [3:0] pos);
        logic idle_seen;
        kind       <= k;
        cell_x     <= x;
        cell_y     <= y;
        handle     <= h;
        slot_index <= pos;
        start      <= 1'b1;
        do begin
            @(negedge clk);
            idle_seen = !busy;
            @(posedge clk);
        end while (!idle_seen);
        sent_by_kind[int'(k)]++;
    endtask

    // bursts of back-to-back items, then a random gap
    task automatic pace_sender();
        int r;
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            r = $urandom_range(0, 9);
            if (r < 3) begin
                gap = 0;
            end else if (r < 9) begin
                gap = $urandom_range(1, 30);
            end else begin
                gap = $urandom_range(31, 120);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy) @(posedge clk);
    endtask

    task automatic set_limit(input logic [4:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_writes++;
    endtask

    initial begin
        logic [5:0]  hot_x [NUM_HOT];
        logic [5:0]  hot_y [NUM_HOT];
        logic [15:0] pool  [POOL_SIZE];
        logic [4:0]  phase_limits [8];
        t_kind       k;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [15:0] h;
        logic [3:0]  pos;
        int          r;
        int          j;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty cell, extreme handles, duplicates, failing deletes
        set_limit(5'd16);
        send_request(KIND_FIND, 6'd0, 6'd0, 16'hFFFF, 4'd0);
        send_request(KIND_DEL_POS, 6'd0, 6'd0, 16'h0000, 4'd0);
        send_request(KIND_DEL_HDL, 6'd0, 6'd0, 16'h0000, 4'd15);
        send_request(KIND_INSERT, 6'd63, 6'd63, 16'h0000, 4'd0);
        send_request(KIND_INSERT, 6'd63, 6'd63, 16'hFFFF, 4'd0);
        send_request(KIND_INSERT, 6'd63, 6'd63, 16'h1234, 4'd0);
        send_request(KIND_INSERT, 6'd63, 6'd63, 16'hFFFF, 4'd0);
        send_request(KIND_FIND, 6'd63, 6'd63, 16'hFFFF, 4'd0);
        send_request(KIND_DEL_HDL, 6'd63, 6'd63, 16'h0000, 4'd0);
        send_request(KIND_DEL_POS, 6'd63, 6'd63, 16'h0000, 4'd15);
        send_request(KIND_DEL_POS, 6'd63, 6'd63, 16'h0000, 4'd3);
        send_request(KIND_DEL_POS, 6'd63, 6'd63, 16'h0000, 4'd2);
        send_request(KIND_FIND, 6'd0, 6'd63, 16'hABCD, 4'd0);
        set_limit(5'd0);
        send_request(KIND_INSERT, 6'd0, 6'd0, 16'h5555, 4'd0);
        // limit above capacity: the seventeenth insert must fail
        set_limit(5'd31);
        for (j = 0; j < 17; j++) begin
            send_request(KIND_INSERT, 6'd5, 6'd9, 16'h8000 | 16'(j), 4'd0);
        end
        send_request(KIND_DEL_POS, 6'd5, 6'd9, 16'h0000, 4'd15);
        send_request(KIND_FIND, 6'd5, 6'd9, 16'h800F, 4'd0);
        send_request(KIND_DEL_HDL, 6'd5, 6'd9, 16'h8000, 4'd0);

        phase_limits = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd8, 5'd17, 5'd0, 5'd16};
        phase_limits[6] = 5'($urandom_range(0, 31));
        foreach (phase_limits[p]) begin
            set_limit(phase_limits[p]);
            for (j = 0; j < NUM_HOT; j++) begin
                hot_x[j] = 6'($urandom_range(0, 63));
                hot_y[j] = 6'($urandom_range(0, 63));
            end
            for (j = 0; j < POOL_SIZE; j++) begin
                pool[j] = 16'($urandom_range(0, 65535));
            end
            pool[0] = 16'h0000;
            pool[1] = 16'hFFFF;
            burst_left = 0;
            for (j = 0; j < PHASE_ITEMS; j++) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    k = KIND_INSERT;
                end else if (r < 65) begin
                    k = KIND_FIND;
                end else if (r < 80) begin
                    k = KIND_DEL_POS;
                end else begin
                    k = KIND_DEL_HDL;
                end
                if ($urandom_range(0, 99) < 85) begin
                    r = $urandom_range(0, NUM_HOT - 1);
                    x = hot_x[r];
                    y = hot_y[r];
                end else begin
                    x = 6'($urandom_range(0, 63));
                    y = 6'($urandom_range(0, 63));
                end
                if ($urandom_range(0, 99) < 70) begin
                    h = pool[$urandom_range(0, POOL_SIZE - 1)];
                end else begin
                    h = 16'($urandom_range(0, 65535));
                end
                if ($urandom_range(0, 1) == 0) begin
                    pos = 4'($urandom_range(0, 4));
                end else begin
                    pos = 4'($urandom_range(0, 15));
                end
                pace_sender();
                send_request(k, x, y, h, pos);
            end
        end

        wait_idle();
        repeat (80) @(posedge clk);
        $display("%0d requests: %0d insert, %0d find, %0d delete at position, %0d delete by handle",
                 sent_by_kind[0] + sent_by_kind[1] + sent_by_kind[2] + sent_by_kind[3],
                 sent_by_kind[0], sent_by_kind[1], sent_by_kind[2], sent_by_kind[3]);
        $display("%0d results checked over %0d cell limit writes, %0d mismatches",
                 checked, limit_writes, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
